>>> hdl/box_filter_3x3_top_defines.svh
// Assertion macros shared by the checker of the box filter.
`ifndef BOX_FILTER_3X3_TOP_DEFINES_SVH
`define BOX_FILTER_3X3_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define BF3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box filter check failed");

// Antecedent implies consequent in the next cycle, outside reset.
`define BF3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box filter check failed");

`endif

>>> hdl/bf3_pkg.sv
package bf3_pkg;

  localparam int PIX_W      = 15;
  localparam int SUM_W      = 19;
  localparam int AVG_W      = 23;
  localparam int ROW_W      = 16;
  localparam int OCOL_W     = 12;
  localparam int QUOT_W     = 15;
  localparam int LW_W       = 13;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Division by nine: q = (sum * RECIP) >> RECIP_SHIFT is exact for sum < 2^21.
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP = 20'd932068;
  localparam int RECIP_SHIFT = 23;

  localparam int MIN_DIM = 3;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 13'd4096;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             start_of_frame;
  } bf3_in_t;

  typedef struct packed {
    logic [AVG_W-1:0]  average;
    logic [ROW_W-1:0]  centre_row;
    logic [OCOL_W-1:0] centre_col;
    logic              frame_done;
  } bf3_out_t;

  typedef struct packed {
    logic [ROW_W-1:0]  centre_row;
    logic [OCOL_W-1:0] centre_col;
    logic              frame_done;
  } bf3_meta_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    bf3_meta_t        meta;
  } bf3_work_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
  } bf3_qstat_t;

  // Fraction bits of (r * 256 + 4) / 9 for a remainder r of the division by nine.
  function automatic logic [7:0] frac_of_rem(input logic [3:0] rem);
    logic [7:0] f;
    case (rem)
      4'd0:    f = 8'd0;
      4'd1:    f = 8'd28;
      4'd2:    f = 8'd57;
      4'd3:    f = 8'd85;
      4'd4:    f = 8'd114;
      4'd5:    f = 8'd142;
      4'd6:    f = 8'd171;
      4'd7:    f = 8'd199;
      4'd8:    f = 8'd228;
      default: f = 8'd0;
    endcase
    return f;
  endfunction

endpackage

>>> hdl/bf3_ram.sv
module bf3_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bf3_front.sv
module bf3_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bf3_pkg::bf3_in_t                 in_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  bf3_pkg::bf3_qstat_t              q_stat,
  output logic                             push_valid,
  output bf3_pkg::bf3_work_t               push_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = ($clog2(MAX_WIDTH + 1) > bf3_pkg::LW_W) ?
                       $clog2(MAX_WIDTH + 1) : bf3_pkg::LW_W;
  localparam int PW  = bf3_pkg::PIX_W;
  localparam int RW  = bf3_pkg::ROW_W;
  localparam int LNW = 2 * PW;

  logic [bf3_pkg::LW_W-1:0] line_width_r;
  logic [bf3_pkg::FH_W-1:0] frame_height_r;

  logic [CW-1:0] col_r, col_cur, col_nxt;
  logic [RW-1:0] row_r, row_cur, row_nxt;
  logic [EW-1:0] w_eff, lw_ext;
  logic [RW-1:0] h_eff;
  logic          last_col, last_row, acc;

  logic                s1_v_r, s1_interior_r;
  logic [PW-1:0]       s1_pix_r;
  logic [CW-1:0]       s1_col_r;
  bf3_pkg::bf3_meta_t  s1_meta_r, meta_cur;

  logic                s2_v_r;
  bf3_pkg::bf3_meta_t  s2_meta_r;

  logic           fwd_hit_r;
  logic [LNW-1:0] fwd_data_r, ram_q, line_rd;
  logic [PW-1:0]  up_pix, mid_pix;

  logic [PW-1:0]            win_r [3][3];
  logic [PW+1:0]            row_sum [3];
  logic [bf3_pkg::SUM_W-1:0] win_sum;

  logic [bf3_pkg::QLVL_W-1:0] in_flight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= bf3_pkg::LINE_WIDTH_RST;
      frame_height_r <= bf3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bf3_pkg::CFG_LINE_WIDTH:   line_width_r   <= cfg_data[bf3_pkg::LW_W-1:0];
        bf3_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[bf3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Only items that may still land in the queue count against its free slots.
  assign in_flight = q_stat.level + bf3_pkg::QLVL_W'(s1_v_r) + bf3_pkg::QLVL_W'(s2_v_r);
  assign in_ready  = in_flight < bf3_pkg::QLVL_W'(bf3_pkg::QDEPTH);
  assign acc       = in_valid && in_ready;

  always_comb begin
    lw_ext = EW'(line_width_r);
    if (lw_ext < EW'(bf3_pkg::MIN_DIM)) begin
      w_eff = EW'(bf3_pkg::MIN_DIM);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    if (frame_height_r < RW'(bf3_pkg::MIN_DIM)) begin
      h_eff = RW'(bf3_pkg::MIN_DIM);
    end else begin
      h_eff = frame_height_r;
    end

    col_cur  = in_data.start_of_frame ? '0 : col_r;
    row_cur  = in_data.start_of_frame ? '0 : row_r;
    last_col = (EW'(col_cur) + EW'(1)) >= w_eff;
    last_row = ({1'b0, row_cur} + (RW + 1)'(1)) >= {1'b0, h_eff};

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_cur + RW'(1);
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end

    meta_cur.centre_row = row_cur - RW'(1);
    meta_cur.centre_col = bf3_pkg::OCOL_W'(col_cur - CW'(1));
    meta_cur.frame_done = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_v_r    <= acc;
      s2_v_r    <= s1_v_r && s1_interior_r;
      fwd_hit_r <= acc && s1_v_r && (col_cur == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r      <= in_data.pixel_value;
      s1_col_r      <= col_cur;
      s1_meta_r     <= meta_cur;
      s1_interior_r <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    end
    fwd_data_r <= {mid_pix, s1_pix_r};
    s2_meta_r  <= s1_meta_r;
  end

  // Each entry holds the column's upper and middle row pixels.
  bf3_ram #(
    .WIDTH(LNW),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (s1_v_r),
    .waddr(s1_col_r),
    .wdata({mid_pix, s1_pix_r}),
    .re   (acc),
    .raddr(col_cur),
    .rdata(ram_q)
  );

  // A write and a read of the same column at the same edge returns stale data.
  assign line_rd = fwd_hit_r ? fwd_data_r : ram_q;
  assign up_pix  = line_rd[LNW-1:PW];
  assign mid_pix = line_rd[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up_pix;
      win_r[1][2] <= mid_pix;
      win_r[2][2] <= s1_pix_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = (PW + 2)'(win_r[r][0]) + (PW + 2)'(win_r[r][1]) +
                   (PW + 2)'(win_r[r][2]);
    end
    win_sum = bf3_pkg::SUM_W'(row_sum[0]) + bf3_pkg::SUM_W'(row_sum[1]) +
              bf3_pkg::SUM_W'(row_sum[2]);
  end

  assign push_valid     = s2_v_r;
  assign push_data.sum  = win_sum;
  assign push_data.meta = s2_meta_r;

endmodule

>>> hdl/bf3_queue.sv
module bf3_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  bf3_pkg::bf3_work_t  push_data,
  output bf3_pkg::bf3_qstat_t q_stat,
  output logic                pop_valid,
  input  logic                pop_ready,
  output bf3_pkg::bf3_work_t  pop_data
);

  bf3_pkg::bf3_work_t               slots_r [bf3_pkg::QDEPTH];
  logic [bf3_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [bf3_pkg::QLVL_W-1:0]       count_r;
  logic                             do_pop;

  // The front only pushes when it has reserved a slot, so no full check here.
  assign do_pop       = pop_valid && pop_ready;
  assign pop_valid    = count_r != '0;
  assign pop_data     = slots_r[rd_ptr_r];
  assign q_stat.level = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + bf3_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bf3_pkg::QPTR_W'(1);
      end
      if (push_valid && !do_pop) begin
        count_r <= count_r + bf3_pkg::QLVL_W'(1);
      end else if (!push_valid && do_pop) begin
        count_r <= count_r - bf3_pkg::QLVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/bf3_back.sv
module bf3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  bf3_pkg::bf3_work_t pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bf3_pkg::bf3_out_t  out_data
);

  localparam int SW = bf3_pkg::SUM_W;
  localparam int QW = bf3_pkg::QUOT_W;
  localparam int PRW = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;

  logic                b1_v_r, out_v_r, out_free, b1_free;
  logic [SW-1:0]       b1_sum_r, rem_full;
  logic [QW-1:0]       b1_quot_r;
  bf3_pkg::bf3_meta_t  b1_meta_r;
  logic [PRW-1:0]      prod;
  bf3_pkg::bf3_out_t   out_r;

  assign out_free  = !out_v_r || out_ready;
  assign b1_free   = !b1_v_r || out_free;
  assign pop_ready = b1_free;

  assign prod = PRW'(pop_data.sum) * PRW'(bf3_pkg::RECIP);

  // Remainder of the division is at most eight; it picks the fraction bits.
  assign rem_full = b1_sum_r - (SW'(b1_quot_r) << 3) - SW'(b1_quot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (b1_free) begin
        b1_v_r <= pop_valid;
      end
      if (out_free) begin
        out_v_r <= b1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_free && pop_valid) begin
      b1_sum_r  <= pop_data.sum;
      b1_quot_r <= prod[bf3_pkg::RECIP_SHIFT +: QW];
      b1_meta_r <= pop_data.meta;
    end
    if (out_free && b1_v_r) begin
      out_r.average    <= {b1_quot_r, 8'h00} +
                          bf3_pkg::AVG_W'(bf3_pkg::frac_of_rem(rem_full[3:0]));
      out_r.centre_row <= b1_meta_r.centre_row;
      out_r.centre_col <= b1_meta_r.centre_col;
      out_r.frame_done <= b1_meta_r.frame_done;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> hdl/box_filter_3x3_top.sv
// A result passes the input stage, the window registers, the queue, the divide stage
// and the output register; it waits in the queue while earlier results wait on out_ready.
// Throughput: one pixel per cycle; in_ready drops only when the four-entry queue
// could not absorb the pixels already in the front pipeline.
// Reset (rst_n low, synchronous): counters, window, queue and valid flags clear,
// both registers return to 4096; the line stores keep their contents.

// The front takes pixels, tracks row and column, keeps the two previous rows in a
// dual-port RAM and shifts the 3x3 window. Pixels whose window lies fully inside
// the frame produce a window sum that goes into a short queue. The back divides
// each sum by nine with a reciprocal multiply, rounds to Q15.8 and holds the item
// in an output register, so a stalled consumer never stalls the pixel stream
// until the queue fills.
module box_filter_3x3_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bf3_pkg::bf3_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bf3_pkg::bf3_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data
);

  bf3_pkg::bf3_qstat_t q_stat;
  bf3_pkg::bf3_work_t  push_data, pop_data;
  logic                push_valid, pop_valid, pop_ready;

  // Front: handshake, counters, line stores, window and window sum.
  bf3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push_valid(push_valid),
    .push_data (push_data)
  );

  // Queue of window sums that decouples the pixel stream from the consumer.
  bf3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_data (push_data),
    .q_stat    (q_stat),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // Back: divide by nine, round, and drive the result channel.
  bf3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> hdl/bf3_chk.sv
`include "box_filter_3x3_top_defines.svh"

module bf3_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input bf3_pkg::bf3_out_t out_data
);

  // A stalled result holds.
  `BF3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Results are never on the top border row.
  `BF3_ASSERT_NOW(a_row_interior, out_valid, out_data.centre_row != 16'd0)

  // The mean of nine 15-bit pixels stays within the Q15.8 range of a pixel.
  `BF3_ASSERT_NOW(a_avg_range, out_valid, out_data.average <= 23'd8388352)

  // Nothing is offered in the first cycle after reset.
  `BF3_ASSERT_NOW(a_reset_quiet, $past(!rst_n), !out_valid)

endmodule

bind box_filter_3x3_top bf3_chk u_bf3_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
